>>> hw/rtl/modbus_rtu_response_detector_assert.svh
// Assertion macros used by the checker module of the response detector.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MODBUS_RTU_RESPONSE_DETECTOR_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mrrd_pkg.sv
// Shared types, codes and the CRC-16 byte update for the response detector.
// Used by mrrd_frame, the top level, the checker and the testbench; depends on nothing.
package mrrd_pkg;

  localparam int unsigned MAX_DATA_BYTES = 63;
  localparam int unsigned APB_ADDR_WIDTH = 3;

  localparam logic [15:0] BYTE_GAP_RESET      = 16'd1719;
  localparam logic [23:0] RESP_TIMEOUT_RESET  = 24'd1000000;
  localparam logic [23:0] ELAPSED_MAX         = 24'hFFFFFF;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;

  localparam logic REG_BYTE_GAP     = 1'b0;
  localparam logic REG_RESP_TIMEOUT = 1'b1;

  localparam logic [1:0] MODE_ARM  = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_RESPONSE = 3'd1;
  localparam logic [2:0] ST_GAP_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_CRC_ERROR   = 3'd3;
  localparam logic [2:0] ST_BAD_FUNC    = 3'd4;
  localparam logic [2:0] ST_COUNT_BIG   = 3'd5;

  localparam logic [7:0] FC_READ_FIRST  = 8'd1;
  localparam logic [7:0] FC_READ_LAST   = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_FIRST,
    PH_FUNC,
    PH_COUNT,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_READ,
    DR_WAIT
  } drain_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic [7:0] payload_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] byte_gap_ticks;
    logic [23:0] response_timeout_ticks;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/mrrd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the payload store of the response detector.
module mrrd_ram #(
  parameter int unsigned Width     = 8,
  parameter int unsigned Depth     = 63,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mrrd_frame.sv
// Frame parser: phase machine, tick timers, CRC, payload store access and drain.
// Depends on mrrd_pkg; drives the write and read ports of one mrrd_ram.
module mrrd_frame #(
  parameter int unsigned MaxDataBytes = mrrd_pkg::MAX_DATA_BYTES,
  parameter int unsigned AddrWidth    = $clog2(MaxDataBytes)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrrd_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mrrd_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mrrd_pkg::out_item_t  out_data_o,
  output logic                 mem_we_o,
  output logic [AddrWidth-1:0] mem_waddr_o,
  output logic [7:0]           mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AddrWidth-1:0] mem_raddr_o,
  input  logic [7:0]           mem_rdata_i
);
  import mrrd_pkg::*;

  localparam int unsigned CntWidth = $clog2(MaxDataBytes + 1);

  phase_e              phase_q, phase_d;
  drain_e              drain_q, drain_d;
  logic [23:0]         elapsed_q, elapsed_d, elapsed_inc;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          func_q, func_d;
  logic [CntWidth-1:0] decl_q, decl_d;
  logic [CntWidth-1:0] rem_q, rem_d;
  logic [15:0]         crc_q, crc_d, crc_next;
  logic [7:0]          crc_lo_q, crc_lo_d;
  logic [AddrWidth-1:0] rd_idx_q, rd_idx_d;
  logic [AddrWidth-1:0] rd_last_q, rd_last_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic                slot_free, in_fire, fail_en, is_read_func;
  logic [2:0]          fail_st;
  logic [7:0]          rx;

  assign slot_free    = !out_valid_q || out_ready_i;
  assign in_ready_o   = (drain_q == DR_IDLE) && slot_free;
  assign in_fire      = in_valid_i && in_ready_o;
  assign rx           = in_data_i.rx_byte;
  assign crc_next     = crc16_byte(crc_q, rx);
  assign elapsed_inc  = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 24'd1;
  assign is_read_func = (func_q >= FC_READ_FIRST) && (func_q <= FC_READ_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      drain_q     <= DR_IDLE;
      elapsed_q   <= '0;
      addr_q      <= '0;
      func_q      <= '0;
      decl_q      <= '0;
      rem_q       <= '0;
      crc_q       <= CRC_INIT;
      crc_lo_q    <= '0;
      rd_idx_q    <= '0;
      rd_last_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      drain_q     <= drain_d;
      elapsed_q   <= elapsed_d;
      addr_q      <= addr_d;
      func_q      <= func_d;
      decl_q      <= decl_d;
      rem_q       <= rem_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
      rd_idx_q    <= rd_idx_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    phase_d     = phase_q;
    drain_d     = drain_q;
    elapsed_d   = elapsed_q;
    addr_d      = addr_q;
    func_d      = func_q;
    decl_d      = decl_q;
    rem_d       = rem_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    rd_idx_d    = rd_idx_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AddrWidth'(decl_q - rem_q);
    mem_wdata_o = rx;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx_q;
    fail_en     = 1'b0;
    fail_st     = ST_OK;

    if (in_fire) begin
      unique case (in_data_i.mode)
        MODE_ARM: begin
          phase_d   = PH_WAIT_FIRST;
          elapsed_d = '0;
          addr_d    = '0;
          func_d    = '0;
          decl_d    = '0;
          rem_d     = '0;
          crc_d     = CRC_INIT;
          crc_lo_d  = '0;
        end
        MODE_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_inc;
            if (phase_q == PH_WAIT_FIRST) begin
              if (elapsed_inc >= cfg_i.response_timeout_ticks) begin
                fail_en = 1'b1;
                fail_st = ST_NO_RESPONSE;
              end
            end else if (elapsed_inc > {8'h00, cfg_i.byte_gap_ticks}) begin
              fail_en = 1'b1;
              fail_st = ST_GAP_TIMEOUT;
            end
          end
        end
        MODE_BYTE: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = '0;
          end
          unique case (phase_q)
            PH_IDLE: ;
            PH_WAIT_FIRST: begin
              addr_d  = rx;
              crc_d   = crc_next;
              phase_d = PH_FUNC;
            end
            PH_FUNC: begin
              func_d = rx;
              crc_d  = crc_next;
              case (rx) inside
                [FC_READ_FIRST:FC_READ_LAST]: begin
                  phase_d = PH_COUNT;
                end
                FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
                  decl_d  = CntWidth'(4);
                  rem_d   = CntWidth'(4);
                  phase_d = PH_DATA;
                end
                default: begin
                  fail_en = 1'b1;
                  fail_st = ST_BAD_FUNC;
                end
              endcase
            end
            PH_COUNT: begin
              crc_d = crc_next;
              if (rx > 8'(MaxDataBytes)) begin
                fail_en = 1'b1;
                fail_st = ST_COUNT_BIG;
              end else begin
                decl_d  = CntWidth'(rx);
                rem_d   = CntWidth'(rx);
                phase_d = (rx == 8'h00) ? PH_CRC_LO : PH_DATA;
              end
            end
            PH_DATA: begin
              crc_d    = crc_next;
              mem_we_o = 1'b1;
              rem_d    = rem_q - CntWidth'(1);
              if (rem_q == CntWidth'(1)) begin
                phase_d = PH_CRC_LO;
              end
            end
            PH_CRC_LO: begin
              crc_lo_d = rx;
              phase_d  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
              phase_d = PH_IDLE;
              if ({rx, crc_lo_q} != crc_q) begin
                fail_en = 1'b1;
                fail_st = ST_CRC_ERROR;
              end else begin
                if (is_read_func) begin
                  out_valid_d = 1'b1;
                  out_d = '{status: ST_OK, slave_address: addr_q, function_code: func_q,
                            payload_byte: 8'(decl_q), last_of_run: (decl_q == '0)};
                end
                if (decl_q != '0) begin
                  drain_d   = DR_READ;
                  rd_idx_d  = '0;
                  rd_last_d = AddrWidth'(decl_q - CntWidth'(1));
                end
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end

    if (fail_en) begin
      phase_d     = PH_IDLE;
      out_valid_d = 1'b1;
      out_d = '{status: fail_st, slave_address: addr_d, function_code: func_d,
                payload_byte: 8'h00, last_of_run: 1'b1};
    end

    unique case (drain_q)
      DR_IDLE: ;
      DR_READ: begin
        mem_re_o = 1'b1;
        drain_d  = DR_WAIT;
      end
      DR_WAIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: ST_OK, slave_address: addr_q, function_code: func_q,
                    payload_byte: mem_rdata_i, last_of_run: (rd_idx_q == rd_last_q)};
          if (rd_idx_q == rd_last_q) begin
            drain_d = DR_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + AddrWidth'(1);
            drain_d  = DR_READ;
          end
        end
      end
      default: drain_d = DR_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/modbus_rtu_response_detector.sv
// Top level of the response detector: APB register file, frame parser, payload RAM.
// Depends on mrrd_pkg, mrrd_frame and mrrd_ram.
//
// An arm word starts waiting for a slave response; byte words are parsed as a Modbus RTU frame
// and tick words drive the response and inter-byte timeouts. Arm, byte and tick words are taken
// one per cycle while the output register is free or being emptied, and otherwise wait for it.
// When a frame passes its CRC the data bytes are read back from the payload RAM one at a time:
// each byte is a read of the RAM and then a load of the output register, which waits while the
// consumer stalls; input stays held off until the last word of the run is loaded.
// An error gives a single word with a zero payload. The RAM needs no clearing after reset.
module modbus_rtu_response_detector #(
  parameter int unsigned MaxDataBytes = mrrd_pkg::MAX_DATA_BYTES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mrrd_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mrrd_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mrrd_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import mrrd_pkg::*;

  localparam int unsigned AddrWidth = $clog2(MaxDataBytes);

  cfg_t                 cfg_q;
  logic                 reg_wr;
  logic                 reg_sel;
  logic                 mem_we;
  logic                 mem_re;
  logic [AddrWidth-1:0] mem_waddr;
  logic [AddrWidth-1:0] mem_raddr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_gap_ticks         <= BYTE_GAP_RESET;
      cfg_q.response_timeout_ticks <= RESP_TIMEOUT_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_BYTE_GAP:     cfg_q.byte_gap_ticks         <= pwdata[15:0];
        REG_RESP_TIMEOUT: cfg_q.response_timeout_ticks <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BYTE_GAP:     prdata = {16'h0000, cfg_q.byte_gap_ticks};
      REG_RESP_TIMEOUT: prdata = {8'h00, cfg_q.response_timeout_ticks};
      default:          prdata = '0;
    endcase
  end

  mrrd_frame #(
    .MaxDataBytes (MaxDataBytes),
    .AddrWidth    (AddrWidth)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  mrrd_ram #(
    .Width     (8),
    .Depth     (MaxDataBytes),
    .AddrWidth (AddrWidth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> hw/rtl/mrrd_checker.sv
// Port-level checker for the response detector, bound to the top level.
// Depends on mrrd_pkg and modbus_rtu_response_detector_assert.svh.
`include "modbus_rtu_response_detector_assert.svh"

module mrrd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mrrd_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mrrd_pkg::out_item_t out_data_o
);
  import mrrd_pkg::*;

  `MRRD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `MRRD_ASSERT_NOW(a_error_single, out_valid_o && (out_data_o.status != ST_OK), out_data_o.last_of_run && (out_data_o.payload_byte == 8'h00))
  `MRRD_ASSERT_NOW(a_run_blocks_input, out_valid_o && !out_data_o.last_of_run, !in_ready_o)
  `MRRD_ASSERT_NEXT(a_arm_silent, in_valid_i && in_ready_o && (in_data_i.mode == MODE_ARM), !out_valid_o)

endmodule

bind modbus_rtu_response_detector mrrd_checker u_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for modbus_rtu_response_detector: directed frames, then random traffic.
// Depends on mrrd_pkg and the detector RTL; predicts every result word and compares in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrd_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int WORDS_PER_PHASE = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef enum {ROW_RAW, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD} row_kind_e;
  typedef enum {
    FR_GOOD, FR_BAD_CRC, FR_BAD_FUNC, FR_BIG_COUNT, FR_GAP, FR_SILENT, FR_ABORT, FR_NOISE
  } frame_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [1:0] mode;
    logic [7:0] data;
    bit typed;
    out_item_t want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predicted detector state and register copies.
  phase_e rx_phase = PH_IDLE;
  logic [23:0] tick_count = '0;
  logic [7:0] frame_addr = '0;
  logic [7:0] frame_func = '0;
  logic [7:0] data_len = '0;
  logic [7:0] data_left = '0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [7:0] crc_lo_byte = '0;
  logic [7:0] data_store [MAX_DATA_BYTES];
  logic [15:0] gap_limit = BYTE_GAP_RESET;
  logic [23:0] resp_limit = RESP_TIMEOUT_RESET;

  out_item_t fresh_words[$];
  out_item_t expected_words[$];
  script_row_t script[$];

  int failures = 0;
  int words_taken = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  modbus_rtu_response_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    logic lsb;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      lsb = r[0];
      r = {1'b0, r[15:1]};
      if (lsb) r ^= CRC_POLY;
    end
    return r;
  endfunction

  function automatic bit known_function(logic [7:0] f);
    return (f >= FC_READ_FIRST && f <= FC_READ_LAST) || f == FC_WRITE_COIL ||
           f == FC_WRITE_REG || f == FC_WRITE_COILS || f == FC_WRITE_REGS;
  endfunction

  function automatic void emit(logic [2:0] st, logic [7:0] pay, logic last);
    fresh_words.push_back('{status: st, slave_address: frame_addr, function_code: frame_func,
                            payload_byte: pay, last_of_run: last});
  endfunction

  function automatic void report_error(logic [2:0] st);
    emit(st, 8'h00, 1'b1);
    rx_phase = PH_IDLE;
  endfunction

  // Returns 1 when the word does something, 0 when the detector ignores it.
  function automatic bit predict(in_item_t w);
    logic [7:0] b;
    b = w.rx_byte;
    fresh_words = {};
    if (w.mode == MODE_ARM) begin
      tick_count = '0;
      frame_addr = '0;
      frame_func = '0;
      data_len = '0;
      data_left = '0;
      crc_acc = CRC_INIT;
      crc_lo_byte = '0;
      rx_phase = PH_WAIT_FIRST;
      return 1'b1;
    end
    if (w.mode == MODE_TICK) begin
      if (rx_phase == PH_IDLE) return 1'b0;
      if (tick_count != ELAPSED_MAX) tick_count++;
      if (rx_phase == PH_WAIT_FIRST) begin
        if (tick_count >= resp_limit) report_error(ST_NO_RESPONSE);
      end else if (tick_count > gap_limit) begin
        report_error(ST_GAP_TIMEOUT);
      end
      return 1'b1;
    end
    if (w.mode != MODE_BYTE || rx_phase == PH_IDLE) return 1'b0;
    tick_count = '0;
    case (rx_phase)
      PH_WAIT_FIRST: begin
        frame_addr = b;
        crc_acc = crc_update(crc_acc, b);
        rx_phase = PH_FUNC;
      end
      PH_FUNC: begin
        frame_func = b;
        crc_acc = crc_update(crc_acc, b);
        if (b >= FC_READ_FIRST && b <= FC_READ_LAST) begin
          rx_phase = PH_COUNT;
        end else if (known_function(b)) begin
          data_len = 8'd4;
          data_left = 8'd4;
          rx_phase = PH_DATA;
        end else begin
          report_error(ST_BAD_FUNC);
        end
      end
      PH_COUNT: begin
        crc_acc = crc_update(crc_acc, b);
        if (b > MAX_DATA_BYTES) begin
          report_error(ST_COUNT_BIG);
        end else begin
          data_len = b;
          data_left = b;
          rx_phase = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_acc = crc_update(crc_acc, b);
        data_store[data_len - data_left] = b;
        data_left--;
        if (data_left == 8'd0) rx_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_lo_byte = b;
        rx_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if ({b, crc_lo_byte} != crc_acc) begin
          report_error(ST_CRC_ERROR);
        end else begin
          if (frame_func >= FC_READ_FIRST && frame_func <= FC_READ_LAST)
            emit(ST_OK, data_len, data_len == 8'd0);
          for (int i = 0; i < data_len; i++) emit(ST_OK, data_store[i], i == data_len - 1);
          rx_phase = PH_IDLE;
        end
      end
      default: begin
        rx_phase = PH_IDLE;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic string describe(out_item_t w);
    return $sformatf("status=%0d addr=%h func=%h payload=%h last=%b", w.status,
                     w.slave_address, w.function_code, w.payload_byte, w.last_of_run);
  endfunction

  function automatic void note_failure(string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic void add_row(row_kind_e kind, logic [1:0] m, logic [7:0] b,
                                  bit typed = 1'b0, logic [2:0] st = ST_OK,
                                  logic [7:0] a = 8'h00, logic [7:0] f = 8'h00);
    script.push_back('{kind: kind, mode: m, data: b, typed: typed,
                       want: '{status: st, slave_address: a, function_code: f,
                               payload_byte: 8'h00, last_of_run: 1'b1}});
  endfunction

  task automatic send_word(logic [1:0] m, logic [7:0] b, bit typed = 1'b0,
                           out_item_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= in_item_t'({m, b});
    do @(posedge clk_i); while (!in_ready_o);
    if (predict(in_item_t'({m, b}))) words_taken++;
    if (typed) expected_words.push_back(want);
    else foreach (fresh_words[i]) expected_words.push_back(fresh_words[i]);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_word(MODE_TICK, 8'($urandom));
  endtask

  task automatic send_frame(frame_kind_e kind, bit longest);
    logic [7:0] frame[$];
    logic [7:0] fc;
    logic [7:0] cnt;
    logic [15:0] crc;
    int stop;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if ((kind == FR_GAP && gap_limit > 16) || (kind == FR_SILENT && resp_limit > 16))
      kind = FR_GOOD;
    send_word(MODE_ARM, 8'($urandom));
    if (kind == FR_SILENT) begin
      send_ticks(resp_limit);
      return;
    end
    send_ticks($urandom_range(0, (resp_limit > 4) ? 3 : resp_limit - 1));
    frame.push_back(8'($urandom));
    if (kind == FR_BAD_FUNC) begin
      do fc = 8'($urandom); while (known_function(fc));
    end else if (longest || kind == FR_BIG_COUNT || $urandom_range(0, 1)) begin
      fc = 8'($urandom_range(FC_READ_FIRST, FC_READ_LAST));
    end else begin
      case ($urandom_range(0, 3))
        0: fc = FC_WRITE_COIL;
        1: fc = FC_WRITE_REG;
        2: fc = FC_WRITE_COILS;
        default: fc = FC_WRITE_REGS;
      endcase
    end
    frame.push_back(fc);
    cnt = 8'd0;
    if (fc >= FC_READ_FIRST && fc <= FC_READ_LAST) begin
      if (kind == FR_BIG_COUNT) cnt = 8'($urandom_range(MAX_DATA_BYTES + 1, 255));
      else if (longest || $urandom_range(0, 24) == 0) cnt = 8'(MAX_DATA_BYTES);
      else cnt = 8'($urandom_range(0, 8));
      frame.push_back(cnt);
    end else if (known_function(fc)) begin
      cnt = 8'd4;
    end
    if (kind != FR_BAD_FUNC && kind != FR_BIG_COUNT) begin
      repeat (cnt) frame.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (frame[i]) crc = crc_update(crc, frame[i]);
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      if (kind == FR_BAD_CRC)
        frame[frame.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    stop = frame.size();
    if (kind == FR_GAP || kind == FR_ABORT) stop = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < stop; i++) begin
      if (i > 0) send_ticks($urandom_range(0, (gap_limit > 3) ? 3 : gap_limit));
      if ($urandom_range(0, 15) == 0) send_word(MODE_RESERVED, 8'($urandom));
      send_word(MODE_BYTE, frame[i]);
    end
    if (kind == FR_GAP) send_ticks(gap_limit + 1);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == REG_BYTE_GAP) ? 32'h0000_FFFF : 32'h00FF_FFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (value & mask))
      note_failure($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_BYTE_GAP) gap_limit = value[15:0];
    else resp_limit = value[23:0];
  endtask

  task automatic random_phase();
    int r;
    words_taken = 0;
    while (words_taken < WORDS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      send_frame(r < 60 ? FR_GOOD : r < 67 ? FR_BAD_CRC : r < 73 ? FR_BAD_FUNC :
                 r < 79 ? FR_BIG_COUNT : r < 85 ? FR_GAP : r < 90 ? FR_SILENT :
                 r < 95 ? FR_ABORT : FR_NOISE, 1'b0);
    end
    send_frame(FR_GOOD, 1'b0);
    wait_for_drain();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        note_failure({"unexpected word: ", describe(out_data_o)});
      end else begin
        want = expected_words.pop_front();
        if (want.status !== out_data_o.status ||
            want.slave_address !== out_data_o.slave_address ||
            want.function_code !== out_data_o.function_code ||
            want.payload_byte !== out_data_o.payload_byte ||
            want.last_of_run !== out_data_o.last_of_run)
          note_failure({"expected ", describe(want), ", got ", describe(out_data_o)});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 14;
    recv_idle_pct = 73;
    write_reg(REG_BYTE_GAP, 32'd0);
    write_reg(REG_RESP_TIMEOUT, 32'd1);

    add_row(ROW_RAW, MODE_BYTE, 8'h55);
    add_row(ROW_RAW, MODE_TICK, 8'hAA);
    add_row(ROW_RAW, MODE_RESERVED, 8'hFF);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_TICK, 8'h00, 1'b1, ST_NO_RESPONSE, 8'h00, 8'h00);
    add_row(ROW_RAW, MODE_ARM, 8'hFF);
    add_row(ROW_RAW, MODE_BYTE, 8'hFF);
    add_row(ROW_RAW, MODE_BYTE, 8'h07, 1'b1, ST_BAD_FUNC, 8'hFF, 8'h07);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'h11);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'h22);
    add_row(ROW_RAW, MODE_BYTE, 8'h03);
    add_row(ROW_RAW, MODE_BYTE, 8'h40, 1'b1, ST_COUNT_BIG, 8'h22, 8'h03);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'h00);
    add_row(ROW_RAW, MODE_TICK, 8'h00, 1'b1, ST_GAP_TIMEOUT, 8'h00, 8'h00);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'h01);
    add_row(ROW_RAW, MODE_BYTE, FC_READ_LAST);
    add_row(ROW_RAW, MODE_BYTE, 8'h00);
    add_row(ROW_CRC_LO, MODE_BYTE, 8'h00);
    add_row(ROW_CRC_HI, MODE_BYTE, 8'h00);
    add_row(ROW_RAW, MODE_ARM, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'h80);
    add_row(ROW_RAW, MODE_BYTE, FC_WRITE_REGS);
    add_row(ROW_RAW, MODE_BYTE, 8'h00);
    add_row(ROW_RAW, MODE_BYTE, 8'hFF);
    add_row(ROW_RAW, MODE_BYTE, 8'hAA);
    add_row(ROW_RAW, MODE_BYTE, 8'h55);
    add_row(ROW_CRC_LO, MODE_BYTE, 8'h00);
    add_row(ROW_CRC_BAD, MODE_BYTE, 8'h00, 1'b1, ST_CRC_ERROR, 8'h80, FC_WRITE_REGS);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CRC_LO: b = crc_acc[7:0];
        ROW_CRC_HI: b = crc_acc[15:8];
        ROW_CRC_BAD: b = crc_acc[15:8] ^ 8'h01;
        default: b = script[i].data;
      endcase
      send_word(script[i].mode, b, script[i].typed, script[i].want);
    end
    wait_for_drain();

    write_reg(REG_BYTE_GAP, 32'd3);
    write_reg(REG_RESP_TIMEOUT, 32'd5);
    random_phase();

    send_idle_pct = 73;
    recv_idle_pct = 14;
    write_reg(REG_BYTE_GAP, 32'd65535);
    write_reg(REG_RESP_TIMEOUT, 32'd16777215);
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BYTE_GAP, 32'd7);
    write_reg(REG_RESP_TIMEOUT, 32'd2);
    // Stall the output while a full-size run and one more frame are offered, then drain.
    hold_req = 1'b1;
    send_frame(FR_GOOD, 1'b1);
    send_frame(FR_GOOD, 1'b0);
    wait_for_drain();
    random_phase();

    if (failures == 0 && expected_words.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
